[design/obm_pkg.sv]
`timescale 1ns / 1ps
package obm_pkg;

   localparam int OBM_COUNT_WIDTH = 10;
   localparam int REG_WIDTH       = 10;
   localparam int CSR_INDEX_WIDTH = 4;
   localparam int CSR_DATA_WIDTH  = 16;
   localparam int NUM_REGS        = 8;

   // operation codes
   localparam logic [1:0] OP_TICK  = 2'd0;
   localparam logic [1:0] OP_RESET = 2'd1;
   localparam logic [1:0] OP_WRITE = 2'd2;
   localparam logic [1:0] OP_READ  = 2'd3;

   // reset status codes
   localparam logic [1:0] ST_PRESENT = 2'd0;
   localparam logic [1:0] ST_ABSENT  = 2'd1;
   localparam logic [1:0] ST_STUCK   = 2'd2;

   // register indexes
   localparam logic [CSR_INDEX_WIDTH-1:0] REG_RESET_LOW     = 4'd0;
   localparam logic [CSR_INDEX_WIDTH-1:0] REG_RESET_RELEASE = 4'd1;
   localparam logic [CSR_INDEX_WIDTH-1:0] REG_PRESENCE_WAIT = 4'd2;
   localparam logic [CSR_INDEX_WIDTH-1:0] REG_PRESENCE_END  = 4'd3;
   localparam logic [CSR_INDEX_WIDTH-1:0] REG_SHORT_LOW     = 4'd4;
   localparam logic [CSR_INDEX_WIDTH-1:0] REG_LONG_SLOT     = 4'd5;
   localparam logic [CSR_INDEX_WIDTH-1:0] REG_READ_SAMPLE   = 4'd6;
   localparam logic [CSR_INDEX_WIDTH-1:0] REG_READ_RECOVER  = 4'd7;

   // register reset values
   localparam logic [REG_WIDTH-1:0] RST_RESET_LOW     = 10'd750;
   localparam logic [REG_WIDTH-1:0] RST_RESET_RELEASE = 10'd15;
   localparam logic [REG_WIDTH-1:0] RST_PRESENCE_WAIT = 10'd200;
   localparam logic [REG_WIDTH-1:0] RST_PRESENCE_END  = 10'd240;
   localparam logic [REG_WIDTH-1:0] RST_SHORT_LOW     = 10'd2;
   localparam logic [REG_WIDTH-1:0] RST_LONG_SLOT     = 10'd60;
   localparam logic [REG_WIDTH-1:0] RST_READ_SAMPLE   = 10'd12;
   localparam logic [REG_WIDTH-1:0] RST_READ_RECOVER  = 10'd50;

   typedef enum logic [3:0] {
      PH_IDLE,
      PH_RST_LOW,
      PH_RST_REL,
      PH_PRES_WAIT,
      PH_PRES_END,
      PH_WR_LOW,
      PH_WR_REL,
      PH_RD_LOW,
      PH_RD_WAIT,
      PH_RD_REC
   } phase_type;

   typedef struct packed {
      logic [REG_WIDTH-1:0] reset_low_ticks;
      logic [REG_WIDTH-1:0] reset_release_ticks;
      logic [REG_WIDTH-1:0] presence_wait_ticks;
      logic [REG_WIDTH-1:0] presence_end_ticks;
      logic [REG_WIDTH-1:0] short_low_ticks;
      logic [REG_WIDTH-1:0] long_slot_ticks;
      logic [REG_WIDTH-1:0] read_sample_ticks;
      logic [REG_WIDTH-1:0] read_recover_ticks;
   } cfg_type;

   typedef struct packed {
      logic       drive_low;
      logic       busy_res;
      logic       done_res;
      logic [1:0] reset_status;
      logic [7:0] read_data;
      logic       rejected;
   } rsp_type;

endpackage

[design/obm_if.sv]
`timescale 1ns / 1ps
interface obm_req_if;
   logic       valid;
   logic       ready;
   logic [1:0] operation;
   logic [7:0] write_data;
   logic       line_level;

   modport source (output valid, output operation, output write_data, output line_level,
                   input ready);
   modport sink (input valid, input operation, input write_data, input line_level,
                 output ready);
endinterface

interface obm_rsp_if;
   logic       valid;
   logic       ready;
   logic       drive_low;
   logic       busy_res;
   logic       done_res;
   logic [1:0] reset_status;
   logic [7:0] read_data;
   logic       rejected;

   modport source (output valid, output drive_low, output busy_res, output done_res,
                   output reset_status, output read_data, output rejected, input ready);
   modport sink (input valid, input drive_low, input busy_res, input done_res,
                 input reset_status, input read_data, input rejected, output ready);
endinterface

interface obm_csr_if;
   logic        valid;
   logic        ready;
   logic [3:0]  index;
   logic [15:0] data;

   modport source (output valid, output index, output data, input ready);
   modport sink (input valid, input index, input data, output ready);
endinterface

[design/obm_csr.sv]
`timescale 1ns / 1ps
module obm_csr import obm_pkg::*; (
   input  logic    clock,
   input  logic    reset,
   obm_csr_if.sink csr_bus,
   output cfg_type cfg
);

   cfg_type cfg_ff;
   cfg_type cfg_in;
   logic [REG_WIDTH-1:0] value;

   assign csr_bus.ready = 1'b1;
   assign value = csr_bus.data[REG_WIDTH-1:0];
   assign cfg = cfg_ff;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_bus.valid) begin
         case (csr_bus.index)
            REG_RESET_LOW:     cfg_in.reset_low_ticks     = value;
            REG_RESET_RELEASE: cfg_in.reset_release_ticks = value;
            REG_PRESENCE_WAIT: cfg_in.presence_wait_ticks = value;
            REG_PRESENCE_END:  cfg_in.presence_end_ticks  = value;
            REG_SHORT_LOW:     cfg_in.short_low_ticks     = value;
            REG_LONG_SLOT:     cfg_in.long_slot_ticks     = value;
            REG_READ_SAMPLE:   cfg_in.read_sample_ticks   = value;
            REG_READ_RECOVER:  cfg_in.read_recover_ticks  = value;
            default:           cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.reset_low_ticks     <= RST_RESET_LOW;
         cfg_ff.reset_release_ticks <= RST_RESET_RELEASE;
         cfg_ff.presence_wait_ticks <= RST_PRESENCE_WAIT;
         cfg_ff.presence_end_ticks  <= RST_PRESENCE_END;
         cfg_ff.short_low_ticks     <= RST_SHORT_LOW;
         cfg_ff.long_slot_ticks     <= RST_LONG_SLOT;
         cfg_ff.read_sample_ticks   <= RST_READ_SAMPLE;
         cfg_ff.read_recover_ticks  <= RST_READ_RECOVER;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

endmodule

[design/obm_core.sv]
`timescale 1ns / 1ps
module obm_core import obm_pkg::*; #(
   parameter int COUNT_WIDTH = OBM_COUNT_WIDTH
) (
   input  logic       clock,
   input  logic       reset,
   input  cfg_type    cfg,
   obm_req_if.sink    req_bus,
   obm_rsp_if.source  rsp_bus
);

   localparam logic [COUNT_WIDTH-1:0] CMAX = '1;
   localparam int CMP_W = (COUNT_WIDTH > REG_WIDTH) ? COUNT_WIDTH : REG_WIDTH;

   phase_type            phase_ff, phase_in, ph_eff;
   logic [COUNT_WIDTH-1:0] cnt_ff, cnt_in, cnt_eff, cnt_inc;
   logic [2:0]           idx_ff, idx_in, idx_eff;
   logic [7:0]           shift_ff, shift_in, shift_eff;
   logic [1:0]           status_ff, status_in;
   logic [REG_WIDTH-1:0] dur;
   logic                 adv;
   logic                 bit_out;
   logic                 accept;
   logic                 rejected;
   rsp_type              rsp_ff, rsp_in;
   logic                 rsp_valid_ff;

   assign req_bus.ready = !rsp_valid_ff || rsp_bus.ready;
   assign accept = req_bus.valid && req_bus.ready;

   // command start overlays the current state
   always_comb begin
      ph_eff    = phase_ff;
      cnt_eff   = cnt_ff;
      idx_eff   = idx_ff;
      shift_eff = shift_ff;
      rejected  = 1'b0;
      if (req_bus.operation != OP_TICK) begin
         if (phase_ff != PH_IDLE) begin
            rejected = 1'b1;
         end else begin
            cnt_eff = '0;
            idx_eff = '0;
            case (req_bus.operation)
               OP_RESET: ph_eff = PH_RST_LOW;
               OP_WRITE: begin
                  ph_eff    = PH_WR_LOW;
                  shift_eff = req_bus.write_data;
               end
               OP_READ: begin
                  ph_eff    = PH_RD_LOW;
                  shift_eff = '0;
               end
               default: ph_eff = phase_ff;
            endcase
         end
      end
   end

   assign bit_out = shift_eff[0];

   always_comb begin
      case (ph_eff)
         PH_RST_LOW:   dur = cfg.reset_low_ticks;
         PH_RST_REL:   dur = cfg.reset_release_ticks;
         PH_PRES_WAIT: dur = cfg.presence_wait_ticks;
         PH_PRES_END:  dur = cfg.presence_end_ticks;
         PH_WR_LOW:    dur = bit_out ? cfg.short_low_ticks : cfg.long_slot_ticks;
         PH_WR_REL:    dur = bit_out ? cfg.long_slot_ticks : cfg.short_low_ticks;
         PH_RD_LOW:    dur = cfg.short_low_ticks;
         PH_RD_WAIT:   dur = cfg.read_sample_ticks;
         PH_RD_REC:    dur = cfg.read_recover_ticks;
         default:      dur = cfg.short_low_ticks;
      endcase
   end

   // saturating tick counter and duration compare
   assign cnt_inc = (cnt_eff < CMAX) ? cnt_eff + 1'b1 : cnt_eff;
   assign adv = (CMP_W'(cnt_inc) >= CMP_W'(dur)) || (cnt_inc == CMAX);

   // next phase
   always_comb begin
      phase_in = ph_eff;
      case (ph_eff)
         PH_IDLE:      phase_in = PH_IDLE;
         PH_RST_LOW:   if (adv) phase_in = PH_RST_REL;
         PH_RST_REL:   if (adv) phase_in = PH_PRES_WAIT;
         PH_PRES_WAIT: begin
            if (!req_bus.line_level) phase_in = PH_PRES_END;
            else if (adv)            phase_in = PH_IDLE;
         end
         PH_PRES_END:  if (req_bus.line_level || adv) phase_in = PH_IDLE;
         PH_WR_LOW:    if (adv) phase_in = PH_WR_REL;
         PH_WR_REL:    if (adv) phase_in = (idx_eff == 3'd7) ? PH_IDLE : PH_WR_LOW;
         PH_RD_LOW:    if (adv) phase_in = PH_RD_WAIT;
         PH_RD_WAIT:   if (adv) phase_in = PH_RD_REC;
         PH_RD_REC:    if (adv) phase_in = (idx_eff == 3'd7) ? PH_IDLE : PH_RD_LOW;
         default:      phase_in = PH_IDLE;
      endcase
   end

   // datapath and result word
   always_comb begin
      cnt_in    = cnt_eff;
      idx_in    = idx_eff;
      shift_in  = shift_eff;
      status_in = status_ff;
      rsp_in    = '0;
      rsp_in.rejected = rejected;
      case (ph_eff)
         PH_IDLE: cnt_in = cnt_eff;
         PH_RST_LOW, PH_RST_REL, PH_WR_LOW, PH_RD_LOW: begin
            rsp_in.drive_low = (ph_eff != PH_RST_REL);
            cnt_in = adv ? '0 : cnt_inc;
         end
         PH_PRES_WAIT: begin
            if (!req_bus.line_level) begin
               cnt_in = '0;
            end else begin
               cnt_in = adv ? '0 : cnt_inc;
               if (adv) begin
                  status_in = ST_ABSENT;
                  rsp_in.done_res = 1'b1;
               end
            end
         end
         PH_PRES_END: begin
            if (req_bus.line_level) begin
               cnt_in = '0;
               status_in = ST_PRESENT;
               rsp_in.done_res = 1'b1;
            end else begin
               cnt_in = adv ? '0 : cnt_inc;
               if (adv) begin
                  status_in = ST_STUCK;
                  rsp_in.done_res = 1'b1;
               end
            end
         end
         PH_WR_REL: begin
            cnt_in = adv ? '0 : cnt_inc;
            if (adv) begin
               shift_in = {1'b0, shift_eff[7:1]};
               if (idx_eff == 3'd7) begin
                  idx_in = '0;
                  rsp_in.done_res = 1'b1;
               end else begin
                  idx_in = idx_eff + 3'd1;
               end
            end
         end
         PH_RD_WAIT: begin
            cnt_in = adv ? '0 : cnt_inc;
            // sample on the last tick of the wait
            if (adv) shift_in = {req_bus.line_level, shift_eff[7:1]};
         end
         PH_RD_REC: begin
            cnt_in = adv ? '0 : cnt_inc;
            if (adv) begin
               if (idx_eff == 3'd7) begin
                  idx_in = '0;
                  rsp_in.done_res  = 1'b1;
                  rsp_in.read_data = shift_eff;
               end else begin
                  idx_in = idx_eff + 3'd1;
               end
            end
         end
         default: cnt_in = cnt_eff;
      endcase
      rsp_in.busy_res     = (phase_in != PH_IDLE);
      rsp_in.reset_status = status_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff  <= PH_IDLE;
         cnt_ff    <= '0;
         idx_ff    <= '0;
         shift_ff  <= '0;
         status_ff <= ST_PRESENT;
      end else if (accept) begin
         phase_ff  <= phase_in;
         cnt_ff    <= cnt_in;
         idx_ff    <= idx_in;
         shift_ff  <= shift_in;
         status_ff <= status_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (accept) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_bus.ready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) rsp_ff <= rsp_in;
   end

   assign rsp_bus.valid        = rsp_valid_ff;
   assign rsp_bus.drive_low    = rsp_ff.drive_low;
   assign rsp_bus.busy_res     = rsp_ff.busy_res;
   assign rsp_bus.done_res     = rsp_ff.done_res;
   assign rsp_bus.reset_status = rsp_ff.reset_status;
   assign rsp_bus.read_data    = rsp_ff.read_data;
   assign rsp_bus.rejected     = rsp_ff.rejected;

endmodule

[design/onewire_bus_master.sv]
`timescale 1ns / 1ps
// Single-wire bus master. Each word on the request channel is one 1 us tick
// carrying the sampled line level and optionally a command (bus reset with
// presence detect, byte write, byte read; bytes go LSB first). Every tick
// yields one response word with the line drive, busy/done flags, the last
// reset status, the received byte on the tick a read completes, and a flag
// for commands rejected while busy. One tick is accepted per clock cycle;
// its response is registered in the output register, and the request side
// stalls only while that register is full and not taken. Slot timings come
// from eight 10-bit registers written over the csr port; the user must
// write them only while the bus is idle, which the block does not enforce.
module onewire_bus_master import obm_pkg::*; #(
   parameter int COUNT_WIDTH = OBM_COUNT_WIDTH
) (
   input  logic      clock,
   input  logic      reset,
   obm_req_if.sink   req_bus,
   obm_rsp_if.source rsp_bus,
   obm_csr_if.sink   csr_bus
);

   cfg_type cfg;

   obm_csr u_csr (
      .clock   (clock),
      .reset   (reset),
      .csr_bus (csr_bus),
      .cfg     (cfg)
   );

   obm_core #(
      .COUNT_WIDTH (COUNT_WIDTH)
   ) u_core (
      .clock   (clock),
      .reset   (reset),
      .cfg     (cfg),
      .req_bus (req_bus),
      .rsp_bus (rsp_bus)
   );

endmodule

[dv/tb_onewire_bus_master.sv]
`timescale 1ns / 1ps
module tb_onewire_bus_master;
   import obm_pkg::*;

   typedef struct packed {
      logic [1:0] operation;
      logic [7:0] write_data;
      logic       line_level;
   } tick_word_type;

   typedef enum int {DEV_PRESENT, DEV_ABSENT, DEV_STUCK, DEV_GARBLED} device_kind_type;

   localparam int LINE_LOW    = 0;
   localparam int LINE_HIGH   = 1;
   localparam int LINE_RANDOM = 2;

   localparam int unsigned COUNT_MAX   = (1 << OBM_COUNT_WIDTH) - 1;
   localparam int          CYCLE_LIMIT = 2000000;

   logic clock;
   logic reset;

   obm_req_if req_if ();
   obm_rsp_if rsp_if ();
   obm_csr_if csr_if ();

   onewire_bus_master dut (
      .clock   (clock),
      .reset   (reset),
      .req_bus (req_if),
      .rsp_bus (rsp_if),
      .csr_bus (csr_if)
   );

   // bus master state as the block should hold it
   phase_type            bus_phase;
   int unsigned          bus_count;
   logic [2:0]           bus_bit;
   logic [7:0]           bus_shift;
   logic [1:0]           bus_status;
   logic [REG_WIDTH-1:0] bus_cfg [1 << CSR_INDEX_WIDTH];

   tick_word_type pending_tick_q[$];
   rsp_type       expected_rsp_q[$];
   tick_word_type driven_word;
   logic          word_taken;

   int send_idle_pct;
   int recv_stall_pct;
   int noise_pct;
   int queued_total;
   int checked_total;
   int error_count;
   int cycle_count;
   int refused_count;
   int cmd_started [4];
   int status_seen [3];

   initial begin
      clock = 1'b0;
      forever #10 clock = ~clock;
   end

   task automatic report_mismatch(input string msg);
      error_count++;
      if (error_count <= 40)
         $display("ERROR at %0t: %s", $time, msg);
   endtask

   task automatic check_field(input string name, input logic [7:0] got, input logic [7:0] want);
      if (got !== want)
         report_mismatch($sformatf("%s got %0h want %0h", name, got, want));
   endtask

   // counts one tick of a timed slot, true when the slot is over
   function automatic bit slot_elapsed(input logic [REG_WIDTH-1:0] dur);
      if (bus_count < COUNT_MAX)
         bus_count++;
      if (bus_count >= dur || bus_count == COUNT_MAX) begin
         bus_count = 0;
         return 1'b1;
      end
      return 1'b0;
   endfunction

   function automatic void end_reset(input logic [1:0] status);
      bus_status = status;
      bus_phase  = PH_IDLE;
      status_seen[status]++;
   endfunction

   function automatic rsp_type predict_tick(input tick_word_type w);
      rsp_type r;
      logic    lsb;
      r = '0;
      if (w.operation != OP_TICK) begin
         if (bus_phase != PH_IDLE) begin
            r.rejected = 1'b1;
            refused_count++;
         end else begin
            bus_count = 0;
            bus_bit   = '0;
            cmd_started[w.operation]++;
            case (w.operation)
               OP_RESET: bus_phase = PH_RST_LOW;
               OP_WRITE: begin
                  bus_shift = w.write_data;
                  bus_phase = PH_WR_LOW;
               end
               default: begin
                  bus_shift = '0;
                  bus_phase = PH_RD_LOW;
               end
            endcase
         end
      end
      lsb = bus_shift[0];
      case (bus_phase)
         PH_RST_LOW: begin
            r.drive_low = 1'b1;
            if (slot_elapsed(bus_cfg[REG_RESET_LOW]))
               bus_phase = PH_RST_REL;
         end
         PH_RST_REL: begin
            if (slot_elapsed(bus_cfg[REG_RESET_RELEASE]))
               bus_phase = PH_PRES_WAIT;
         end
         PH_PRES_WAIT: begin
            if (!w.line_level) begin
               bus_count = 0;
               bus_phase = PH_PRES_END;
            end else if (slot_elapsed(bus_cfg[REG_PRESENCE_WAIT])) begin
               end_reset(ST_ABSENT);
               r.done_res = 1'b1;
            end
         end
         PH_PRES_END: begin
            if (w.line_level) begin
               bus_count = 0;
               end_reset(ST_PRESENT);
               r.done_res = 1'b1;
            end else if (slot_elapsed(bus_cfg[REG_PRESENCE_END])) begin
               end_reset(ST_STUCK);
               r.done_res = 1'b1;
            end
         end
         PH_WR_LOW: begin
            r.drive_low = 1'b1;
            if (slot_elapsed(lsb ? bus_cfg[REG_SHORT_LOW] : bus_cfg[REG_LONG_SLOT]))
               bus_phase = PH_WR_REL;
         end
         PH_WR_REL: begin
            if (slot_elapsed(lsb ? bus_cfg[REG_LONG_SLOT] : bus_cfg[REG_SHORT_LOW])) begin
               bus_shift = bus_shift >> 1;
               if (bus_bit == 3'd7) begin
                  bus_bit    = '0;
                  bus_phase  = PH_IDLE;
                  r.done_res = 1'b1;
               end else begin
                  bus_bit++;
                  bus_phase = PH_WR_LOW;
               end
            end
         end
         PH_RD_LOW: begin
            r.drive_low = 1'b1;
            if (slot_elapsed(bus_cfg[REG_SHORT_LOW]))
               bus_phase = PH_RD_WAIT;
         end
         PH_RD_WAIT: begin
            if (slot_elapsed(bus_cfg[REG_READ_SAMPLE])) begin
               bus_shift = {w.line_level, bus_shift[7:1]};
               bus_phase = PH_RD_REC;
            end
         end
         PH_RD_REC: begin
            if (slot_elapsed(bus_cfg[REG_READ_RECOVER])) begin
               if (bus_bit == 3'd7) begin
                  bus_bit     = '0;
                  bus_phase   = PH_IDLE;
                  r.done_res  = 1'b1;
                  r.read_data = bus_shift;
               end else begin
                  bus_bit++;
                  bus_phase = PH_RD_LOW;
               end
            end
         end
         default: bus_phase = PH_IDLE;
      endcase
      r.busy_res     = (bus_phase != PH_IDLE);
      r.reset_status = bus_status;
      return r;
   endfunction

   // request driver
   always @(posedge clock) begin
      if (!reset && req_if.valid && req_if.ready) begin
         expected_rsp_q.push_back(predict_tick(driven_word));
         word_taken <= 1'b1;
      end else begin
         word_taken <= 1'b0;
      end
   end

   always @(negedge clock) begin : drive_req
      tick_word_type w;
      if (reset) begin
         req_if.valid <= 1'b0;
      end else if (!req_if.valid || word_taken) begin
         if (pending_tick_q.size() > 0 && $urandom_range(0, 99) >= send_idle_pct) begin
            w = pending_tick_q.pop_front();
            driven_word          <= w;
            req_if.operation  <= w.operation;
            req_if.write_data <= w.write_data;
            req_if.line_level <= w.line_level;
            req_if.valid      <= 1'b1;
         end else begin
            req_if.valid <= 1'b0;
         end
      end
   end

   always @(negedge clock) begin
      rsp_if.ready <= !reset && ($urandom_range(0, 99) >= recv_stall_pct);
   end

   // response monitor
   always @(posedge clock) begin : check_rsp
      rsp_type want;
      if (!reset && rsp_if.valid && rsp_if.ready) begin
         checked_total++;
         if (expected_rsp_q.size() == 0) begin
            report_mismatch("response word with nothing outstanding");
         end else begin
            want = expected_rsp_q.pop_front();
            check_field("drive_low", 8'(rsp_if.drive_low), 8'(want.drive_low));
            check_field("busy_res", 8'(rsp_if.busy_res), 8'(want.busy_res));
            check_field("done_res", 8'(rsp_if.done_res), 8'(want.done_res));
            check_field("reset_status", 8'(rsp_if.reset_status), 8'(want.reset_status));
            check_field("read_data", rsp_if.read_data, want.read_data);
            check_field("rejected", 8'(rsp_if.rejected), 8'(want.rejected));
         end
      end
   end

   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("timeout after %0d cycles, %0d words outstanding",
                  cycle_count, queued_total - checked_total);
         $display("FAILED: results differ");
         $finish;
      end
   end

   task automatic queue_tick(input logic [1:0] op, input logic [7:0] data, input logic line);
      tick_word_type w;
      w.operation  = op;
      w.write_data = data;
      w.line_level = line;
      pending_tick_q.push_back(w);
      queued_total++;
   endtask

   task automatic queue_ticks(input int n, input int line_mode);
      logic [1:0] op;
      for (int i = 0; i < n; i++) begin
         op = ($urandom_range(0, 99) < noise_pct) ? 2'($urandom_range(1, 3)) : OP_TICK;
         queue_tick(op, 8'($urandom),
                    (line_mode == LINE_RANDOM) ? 1'($urandom) : 1'(line_mode));
      end
   endtask

   // a command on the last tick of the previous one must be refused
   task automatic set_last_op(input logic [1:0] op);
      tick_word_type w;
      if (op != OP_TICK) begin
         w = pending_tick_q.pop_back();
         w.operation = op;
         pending_tick_q.push_back(w);
      end
   endtask

   function automatic int slot_len(input logic [CSR_INDEX_WIDTH-1:0] idx);
      return (bus_cfg[idx] == 0) ? 1 : int'(bus_cfg[idx]);
   endfunction

   function automatic int pick_span(input int lo, input int hi);
      case ($urandom_range(0, 3))
         0: return lo;
         1: return hi;
         default: return $urandom_range(lo, hi);
      endcase
   endfunction

   task automatic queue_reset(input device_kind_type kind);
      int lead, wait_len, end_len;
      lead     = slot_len(REG_RESET_LOW) + slot_len(REG_RESET_RELEASE);
      wait_len = slot_len(REG_PRESENCE_WAIT);
      end_len  = slot_len(REG_PRESENCE_END);
      queue_tick(OP_RESET, 8'($urandom), 1'($urandom));
      queue_ticks(lead - 1, LINE_RANDOM);
      case (kind)
         DEV_ABSENT:  queue_ticks(wait_len, LINE_HIGH);
         DEV_GARBLED: queue_ticks($urandom_range(0, wait_len + end_len + 2), LINE_RANDOM);
         default: begin
            queue_ticks(pick_span(0, wait_len - 1), LINE_HIGH);
            // first low tick only opens the release window
            if (kind == DEV_STUCK) begin
               queue_ticks(end_len + 1, LINE_LOW);
            end else begin
               queue_ticks(pick_span(1, end_len), LINE_LOW);
               queue_ticks(1, LINE_HIGH);
            end
         end
      endcase
   endtask

   task automatic queue_write(input logic [7:0] data, input logic [1:0] last_op);
      queue_tick(OP_WRITE, data, 1'($urandom));
      queue_ticks(8 * (slot_len(REG_SHORT_LOW) + slot_len(REG_LONG_SLOT)) - 1, LINE_RANDOM);
      set_last_op(last_op);
   endtask

   task automatic queue_read(input int line_mode, input logic [1:0] last_op);
      queue_tick(OP_READ, 8'($urandom), 1'($urandom));
      queue_ticks(8 * (slot_len(REG_SHORT_LOW) + slot_len(REG_READ_SAMPLE)
                       + slot_len(REG_READ_RECOVER)) - 1, line_mode);
      set_last_op(last_op);
   endtask

   function automatic logic [1:0] random_last_op();
      return ($urandom_range(0, 99) < 15) ? 2'($urandom_range(1, 3)) : OP_TICK;
   endfunction

   task automatic run_random_mix(input int n_ticks);
      int start;
      int pick;
      start = queued_total;
      while (queued_total - start < n_ticks) begin
         pick = $urandom_range(0, 99);
         if (pick < 32) begin
            queue_write(8'($urandom), random_last_op());
         end else if (pick < 64) begin
            queue_read(LINE_RANDOM, random_last_op());
         end else if (pick < 75) begin
            queue_reset(DEV_PRESENT);
         end else if (pick < 83) begin
            queue_reset(DEV_ABSENT);
         end else if (pick < 91) begin
            queue_reset(DEV_STUCK);
         end else if (pick < 95) begin
            queue_reset(DEV_GARBLED);
         end else begin
            noise_pct = 30;
            queue_ticks($urandom_range(1, 12), LINE_RANDOM);
            noise_pct = 3;
         end
         queue_ticks($urandom_range(0, 2), LINE_RANDOM);
      end
   endtask

   task automatic wait_all_checked();
      while (checked_total != queued_total)
         @(posedge clock);
   endtask

   // registers may only change with the bus idle and nothing in flight
   task automatic drain_bus();
      int saved_noise;
      saved_noise = noise_pct;
      noise_pct   = 0;
      wait_all_checked();
      while (bus_phase != PH_IDLE) begin
         queue_ticks(16, LINE_HIGH);
         wait_all_checked();
      end
      noise_pct = saved_noise;
      repeat (4) @(posedge clock);
   endtask

   task automatic write_csr(input logic [CSR_INDEX_WIDTH-1:0] idx,
                            input logic [CSR_DATA_WIDTH-1:0] value);
      @(negedge clock);
      csr_if.valid <= 1'b1;
      csr_if.index <= idx;
      csr_if.data  <= value;
      do @(posedge clock); while (!csr_if.ready);
      if (idx < NUM_REGS)
         bus_cfg[idx] = value[REG_WIDTH-1:0];
      @(negedge clock);
      csr_if.valid <= 1'b0;
   endtask

   task automatic program_timing(input logic [15:0] low_t, rel_t, pw_t, pe_t,
                                 input logic [15:0] sh_t, lg_t, rs_t, rr_t);
      write_csr(REG_RESET_LOW, low_t);
      write_csr(REG_RESET_RELEASE, rel_t);
      write_csr(REG_PRESENCE_WAIT, pw_t);
      write_csr(REG_PRESENCE_END, pe_t);
      write_csr(REG_SHORT_LOW, sh_t);
      write_csr(REG_LONG_SLOT, lg_t);
      write_csr(REG_READ_SAMPLE, rs_t);
      write_csr(REG_READ_RECOVER, rr_t);
   endtask

   // mostly short slots so random phases stay fast, upper bits are junk
   function automatic logic [15:0] random_timing();
      logic [9:0] v;
      if ($urandom_range(0, 9) == 0)
         v = 10'($urandom_range(7, 40));
      else
         v = 10'($urandom_range(0, 6));
      return {6'($urandom), v};
   endfunction

   task automatic set_idling(input int send_pct, input int recv_pct);
      send_idle_pct  = send_pct;
      recv_stall_pct = recv_pct;
   endtask

   initial begin
      reset             = 1'b1;
      word_taken        = 1'b0;
      req_if.valid      = 1'b0;
      req_if.operation  = OP_TICK;
      req_if.write_data = '0;
      req_if.line_level = 1'b1;
      rsp_if.ready      = 1'b0;
      csr_if.valid      = 1'b0;
      csr_if.index      = REG_RESET_LOW;
      csr_if.data       = '0;
      bus_phase  = PH_IDLE;
      bus_count  = 0;
      bus_bit    = '0;
      bus_shift  = '0;
      bus_status = ST_PRESENT;
      foreach (bus_cfg[i])
         bus_cfg[i] = '0;
      bus_cfg[REG_RESET_LOW]     = RST_RESET_LOW;
      bus_cfg[REG_RESET_RELEASE] = RST_RESET_RELEASE;
      bus_cfg[REG_PRESENCE_WAIT] = RST_PRESENCE_WAIT;
      bus_cfg[REG_PRESENCE_END]  = RST_PRESENCE_END;
      bus_cfg[REG_SHORT_LOW]     = RST_SHORT_LOW;
      bus_cfg[REG_LONG_SLOT]     = RST_LONG_SLOT;
      bus_cfg[REG_READ_SAMPLE]   = RST_READ_SAMPLE;
      bus_cfg[REG_READ_RECOVER]  = RST_READ_RECOVER;
      set_idling(0, 0);
      noise_pct = 0;
      repeat (10) @(negedge clock);
      reset <= 1'b0;

      // directed sequence on the reset timings
      queue_tick(OP_TICK, 8'h00, 1'b0);
      queue_tick(OP_TICK, 8'hFF, 1'b1);
      queue_reset(DEV_ABSENT);
      drain_bus();

      // indexes past the register file must be ignored
      for (int i = 0; i < 4; i++)
         write_csr(CSR_INDEX_WIDTH'(NUM_REGS + $urandom_range(0, 7)), 16'($urandom));

      // zero timings behave as one tick
      set_idling(51, 0);
      noise_pct = 3;
      program_timing(16'hFC00, 16'h0000, 16'h0400, 16'h0000,
                     16'h0000, 16'h8000, 16'h0000, 16'h0000);
      run_random_mix(120);
      drain_bus();

      set_idling(0, 51);
      program_timing(16'h0001, 16'h0001, 16'h0001, 16'h0001,
                     16'h0001, 16'h0001, 16'h0001, 16'h0001);
      run_random_mix(120);
      drain_bus();

      for (int mode = 0; mode < 4; mode++) begin
         case (mode)
            0: set_idling(0, 0);
            1: set_idling(51, 0);
            2: set_idling(0, 51);
            default: set_idling(11, 11);
         endcase
         program_timing(random_timing(), random_timing(), random_timing(), random_timing(),
                        random_timing(), random_timing(), random_timing(), random_timing());
         run_random_mix(80);
         drain_bus();
      end

      repeat (20) @(posedge clock);
      if (expected_rsp_q.size() != 0)
         report_mismatch($sformatf("%0d response words never arrived", expected_rsp_q.size()));
      $display("covered %0d ticks: %0d resets (%0d present, %0d absent, %0d stuck), "
               , queued_total, cmd_started[OP_RESET], status_seen[ST_PRESENT],
               status_seen[ST_ABSENT], status_seen[ST_STUCK]);
      $display("%0d writes, %0d reads, %0d refused while busy, %0d words checked, %0d errors",
               cmd_started[OP_WRITE], cmd_started[OP_READ], refused_count,
               checked_total, error_count);
      if (error_count == 0)
         $display("PASSED: all results match");
      else
         $display("FAILED: results differ");
      $finish;
   end

endmodule
